/* sv/ucfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucfr_pkg: shared types and constants of the command frame receiver
// Holds the command codes, the last byte index of each field and the result word structure.
// ----------------------------------------------------------------------------
package ucfr_pkg;

   // start byte after reset ('A')
   localparam logic [7:0] START_RESET  = 8'h41;

   // command codes
   localparam logic [7:0] CMD_TOGGLE_A = 8'h31;
   localparam logic [7:0] CMD_TOGGLE_B = 8'hD2;
   localparam logic [7:0] CMD_NOP_C    = 8'hD3;
   localparam logic [7:0] CMD_NOP_D    = 8'hD4;

   // index of the last byte of each multi-byte field
   localparam logic [1:0] PARAM_LAST   = 2'd1;
   localparam logic [1:0] PAYLOAD_LAST = 2'd3;

   // one result word
   typedef struct packed {
      logic [7:0]  command;
      logic [15:0] parameter_res;
      logic [31:0] payload;
      logic        light_a;
      logic        light_b;
   } rsp_word_type;

endpackage
`default_nettype wire

/* sv/ucfr_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucfr_if: valid/ready channels of the command frame receiver
// Byte request channel and frame result channel.
// ----------------------------------------------------------------------------
interface ucfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ucfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  command;
   logic [15:0] parameter_res;
   logic [31:0] payload;
   logic        light_a;
   logic        light_b;

   modport source (output valid, output command, output parameter_res, output payload,
                   output light_a, output light_b, input ready);
   modport sink   (input valid, input command, input parameter_res, input payload,
                   input light_a, input light_b, output ready);
endinterface
`default_nettype wire

/* sv/uart_command_frame_receiver.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_command_frame_receiver: start-of-frame command frame receiver
// Takes received bytes, assembles command/parameter/payload frames and
// reports each completed frame with the resulting light states.
// ----------------------------------------------------------------------------
//  channel  direction  word
//  req_ch   in         rx_byte (8)
//  rsp_ch   out        command (8), parameter_res (16), payload (32), light_a, light_b
//  csr_     in         wr_en, wr_data (8): start byte
//
//  One byte per cycle while the pipeline advances; a result leaves once the last payload
//  byte has passed the input register, then the result register.
//  The pipeline advances when the result register is empty or being taken;
//  the input register still accepts a byte while a result waits, if it is empty.
//  Synchronous reset restores hunting, lights off and start byte 0x41.
// ----------------------------------------------------------------------------
module uart_command_frame_receiver (
   input  wire logic       clock,
   input  wire logic       reset,
   ucfr_req_if.sink        req_ch,
   ucfr_rsp_if.source      rsp_ch,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);
   import ucfr_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;
   logic [7:0]   start_byte_ff;
   logic         advance;
   logic         req_fire;
   logic         out_valid;
   rsp_word_type out_word;

   assign advance  = ~out_valid | rsp_ch.ready;
   assign req_fire = req_ch.valid & req_ch.ready;

   // input register
   assign req_ch.ready = ~in_valid_ff | advance;
   assign in_valid_in  = req_fire | (in_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_fire) in_byte_ff <= req_ch.rx_byte;
   end

   // start byte register
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_RESET;
      end else if (csr_wr_en) begin
         start_byte_ff <= csr_wr_data;
      end
   end

   ucfr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (in_valid_ff),
      .in_byte    (in_byte_ff),
      .advance    (advance),
      .start_byte (start_byte_ff),
      .out_valid  (out_valid),
      .out_word   (out_word)
   );

   // result channel
   assign rsp_ch.valid         = out_valid;
   assign rsp_ch.command       = out_word.command;
   assign rsp_ch.parameter_res = out_word.parameter_res;
   assign rsp_ch.payload       = out_word.payload;
   assign rsp_ch.light_a       = out_word.light_a;
   assign rsp_ch.light_b       = out_word.light_b;

   // checks
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ch.ready)
      else $error("input register empty but not ready");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid after reset");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(in_valid_ff))
      else $error("result without a byte in the input register");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("byte accepted into a full stalled pipeline");

endmodule
`default_nettype wire

/* sv/ucfr_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucfr_parser: frame state machine and result register
// Hunts for the start byte, collects command, parameter and payload bytes,
// toggles the lights and registers one result word per completed frame.
// ----------------------------------------------------------------------------
module ucfr_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic [7:0]            in_byte,
   input  wire logic                  advance,
   input  wire logic [7:0]            start_byte,
   output      logic                  out_valid,
   output      ucfr_pkg::rsp_word_type out_word
);
   import ucfr_pkg::*;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_CMD,
      PH_PARAM,
      PH_PAYLOAD
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic [1:0]   byte_index_ff, byte_index_in;
   logic [7:0]   command_ff, command_in;
   logic [15:0]  parameter_ff, parameter_in;
   logic [31:0]  payload_ff, payload_in;
   logic         light_a_ff, light_a_in;
   logic         light_b_ff, light_b_in;
   logic         valid_ff, valid_in;
   rsp_word_type word_ff, word_in;
   logic         take;
   logic         done;

   assign take = in_valid & advance;

   // next state for one byte
   always_comb begin
      phase_in      = phase_ff;
      byte_index_in = byte_index_ff;
      command_in    = command_ff;
      parameter_in  = parameter_ff;
      payload_in    = payload_ff;
      light_a_in    = light_a_ff;
      light_b_in    = light_b_ff;
      done          = 1'b0;
      case (phase_ff)
         PH_HUNT: begin
            if (in_byte == start_byte) phase_in = PH_CMD;
         end
         PH_CMD: begin
            command_in    = in_byte;
            byte_index_in = 2'd0;
            phase_in      = PH_PARAM;
         end
         PH_PARAM: begin
            parameter_in = {in_byte, parameter_ff[15:8]};
            if (byte_index_ff >= PARAM_LAST) begin
               byte_index_in = 2'd0;
               phase_in      = PH_PAYLOAD;
            end else begin
               byte_index_in = byte_index_ff + 2'd1;
            end
         end
         PH_PAYLOAD: begin
            payload_in = {in_byte, payload_ff[31:8]};
            if (byte_index_ff == PAYLOAD_LAST) begin
               byte_index_in = 2'd0;
               phase_in      = PH_HUNT;
               done          = 1'b1;
               case (command_ff)
                  CMD_TOGGLE_A: light_a_in = ~light_a_ff;
                  CMD_TOGGLE_B: light_b_in = ~light_b_ff;
                  CMD_NOP_C:    ;
                  CMD_NOP_D:    ;
                  default:      ;
               endcase
            end else begin
               byte_index_in = byte_index_ff + 2'd1;
            end
         end
         default: phase_in = PH_HUNT;
      endcase
   end

   // result word and its valid flag
   always_comb begin
      word_in.command       = command_ff;
      word_in.parameter_res = parameter_ff;
      word_in.payload       = payload_in;
      word_in.light_a       = light_a_in;
      word_in.light_b       = light_b_in;
      valid_in              = advance ? (take & done) : valid_ff;
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         byte_index_ff <= 2'd0;
         command_ff    <= 8'd0;
         parameter_ff  <= 16'd0;
         payload_ff    <= 32'd0;
         light_a_ff    <= 1'b0;
         light_b_ff    <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            phase_ff      <= phase_in;
            byte_index_ff <= byte_index_in;
            command_ff    <= command_in;
            parameter_ff  <= parameter_in;
            payload_ff    <= payload_in;
            light_a_ff    <= light_a_in;
            light_b_ff    <= light_b_in;
         end
      end
      if (take && done) word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule
`default_nettype wire
